// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file blt_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define BLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every edge, reset included.
`define BLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/blt_pkg.sv =====
// Shared constants, codes, command/status structs and the bank hash.
// No dependencies.
package blt_pkg;

    localparam int MAX_LINES   = 256;
    localparam int LINE_IW     = $clog2(MAX_LINES);
    localparam int LCNT_W      = LINE_IW + 1;
    localparam int RANK_W      = LINE_IW;
    localparam int MAX_BANKS   = 16;
    localparam int BANK_W      = $clog2(MAX_BANKS);
    localparam int BCNT_W      = 5;
    localparam int ADDR_BITS   = 48;
    localparam int DIVC_W      = $clog2(ADDR_BITS + 1);
    localparam int STAMP_W     = 32;
    localparam int CTR_W       = 32;
    localparam int SHIFT_W     = 4;
    localparam int ACT_W       = 9;
    localparam int POLICY_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int ENTRY_W     = ADDR_BITS + RANK_W;

    localparam int ROW_LINES   = 64;
    localparam int ROW_SHIFT   = $clog2(ROW_LINES);
    localparam int XOR_SHIFT_A = 7;
    localparam int XOR_SHIFT_B = 13;
    localparam int HYB_SHIFT   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    localparam logic [POLICY_W-1:0] POL_PLAIN  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_ROW    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_XOR    = 2'd2;
    localparam logic [POLICY_W-1:0] POL_HYBRID = 2'd3;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic check;
        logic srch;
        logic srch_end;
        logic upd;
        logic sweep_clr;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic in_fill;
        logic enable;
        logic lim_zero;
        logic div_done;
        logic bank_busy;
        logic sweep_done;
        logic line_hit;
        logic is_fill;
        logic upd_needed;
        logic out_free;
    } t_stat;

    function automatic logic [ADDR_BITS-1:0] bank_hash(input logic [ADDR_BITS-1:0] la,
                                                       input logic [POLICY_W-1:0] pol);
        logic [ADDR_BITS-1:0] h;
        case (pol)
            POL_ROW:    h = la >> ROW_SHIFT;
            POL_XOR:    h = la ^ (la >> XOR_SHIFT_A) ^ (la >> XOR_SHIFT_B);
            POL_HYBRID: h = (la >> ROW_SHIFT) ^ la ^ (la >> HYB_SHIFT);
            default:    h = la;
        endcase
        return h;
    endfunction

endpackage

// ===== design/blt_req_if.sv =====
// Request channel: valid/ready plus command, address and cycle stamp.
// Depends on blt_pkg.
interface blt_req_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [blt_pkg::ADDR_BITS-1:0]    address;
    logic [blt_pkg::STAMP_W-1:0]      now;

    modport source (output valid, command, address, now, input ready);
    modport sink   (input valid, command, address, now, output ready);
endinterface

// ===== design/blt_rsp_if.sv =====
// Response channel: valid/ready plus status, bank and the four totals.
// Depends on blt_pkg.
interface blt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [blt_pkg::STATUS_W-1:0]     status;
    logic [blt_pkg::BANK_W-1:0]       bank;
    logic [blt_pkg::CTR_W-1:0]        access_total;
    logic [blt_pkg::CTR_W-1:0]        hit_total;
    logic [blt_pkg::CTR_W-1:0]        miss_total;
    logic [blt_pkg::CTR_W-1:0]        fail_total;

    modport source (output valid, status, bank, access_total, hit_total, miss_total,
                    fail_total, input ready);
    modport sink   (input valid, status, bank, access_total, hit_total, miss_total,
                    fail_total, output ready);
endinterface

// ===== design/blt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module blt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/blt_ctrl.sv =====
// Sequencer: accept, bank divide, busy check, search sweep, update sweep, result.
// Depends on blt_pkg.
module blt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  blt_pkg::t_stat i_st,
    output logic           o_in_ready,
    output blt_pkg::t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_CHECK  = 6'b000100,
        S_SRCH   = 6'b001000,
        S_UPD    = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_st.enable) begin
                        n_state = i_st.in_fill ? S_IDLE : S_RESULT;
                    end else if (i_st.in_fill) begin
                        if (!i_st.lim_zero) begin
                            n_state         = S_SRCH;
                            o_cmd.sweep_clr = 1'b1;
                        end
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_st.div_done) n_state = S_CHECK;
                else o_cmd.div_step = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_st.bank_busy) begin
                    n_state = S_RESULT;
                end else begin
                    n_state         = S_SRCH;
                    o_cmd.sweep_clr = 1'b1;
                end
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_st.sweep_done) begin
                    o_cmd.srch_end  = 1'b1;
                    o_cmd.sweep_clr = 1'b1;
                    if (i_st.is_fill) n_state = i_st.upd_needed ? S_UPD : S_IDLE;
                    else n_state = i_st.line_hit ? S_UPD : S_RESULT;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_st.sweep_done) n_state = i_st.is_fill ? S_IDLE : S_RESULT;
            end
            S_RESULT: begin
                if (i_st.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== design/blt_dp.sv =====
// Datapath: config registers, bit-serial bank divider, bank busy stamps,
// tag/rank RAM sweeps, valid bits, counters and the output register.
// Depends on blt_pkg and blt_ram.
module blt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [blt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  blt_pkg::t_cmd                     i_cmd,
    output blt_pkg::t_stat                    o_st,
    input  logic                              i_req_command,
    input  logic [blt_pkg::ADDR_BITS-1:0]     i_req_address,
    input  logic [blt_pkg::STAMP_W-1:0]       i_req_now,
    input  logic                              i_rsp_ready,
    output logic                              o_rsp_valid,
    output logic [blt_pkg::STATUS_W-1:0]      o_status,
    output logic [blt_pkg::BANK_W-1:0]        o_bank,
    output logic [blt_pkg::CTR_W-1:0]         o_access_total,
    output logic [blt_pkg::CTR_W-1:0]         o_hit_total,
    output logic [blt_pkg::CTR_W-1:0]         o_miss_total,
    output logic [blt_pkg::CTR_W-1:0]         o_fail_total
);
    localparam int LW = blt_pkg::LINE_IW;
    localparam int AW = blt_pkg::ADDR_BITS;
    localparam int RW = blt_pkg::RANK_W;
    localparam int CW = blt_pkg::CTR_W;
    localparam int NW = blt_pkg::LCNT_W;

    // config
    logic                          r_en;
    logic [blt_pkg::SHIFT_W-1:0]   r_shift;
    logic [blt_pkg::ACT_W-1:0]     r_act;
    logic [blt_pkg::BCNT_W-1:0]    r_bcnt;
    logic [blt_pkg::POLICY_W-1:0]  r_pol;

    // current item
    logic                          r_fill;
    logic [AW-1:0]                 r_la;
    logic [blt_pkg::STAMP_W-1:0]   r_now;

    // bank divider
    logic [AW-1:0]                 r_dq;
    logic [blt_pkg::BANK_W-1:0]    r_rem;
    logic [blt_pkg::DIVC_W-1:0]    r_dcnt;

    logic [blt_pkg::STAMP_W-1:0]   r_busy [blt_pkg::MAX_BANKS];
    logic [CW-1:0]                 r_acc, r_hitc, r_missc, r_failc;
    logic [blt_pkg::STATUS_W-1:0]  r_status;
    logic [blt_pkg::BANK_W-1:0]    r_bank;
    logic [blt_pkg::MAX_LINES-1:0] r_valid;
    logic [NW-1:0]                 r_rc;

    // sweep pipeline
    logic [NW-1:0]                 r_idx;
    logic                          r_rv;
    logic [LW-1:0]                 r_rp;

    // search results
    logic                          r_hit, r_hf, r_vf, r_ins;
    logic [LW-1:0]                 r_hs, r_fs, r_vs, r_slot;
    logic [RW-1:0]                 r_hr;

    // output register
    logic                          r_ov;
    logic [blt_pkg::STATUS_W-1:0]  r_o_status;
    logic [blt_pkg::BANK_W-1:0]    r_o_bank;
    logic [CW-1:0]                 r_o_acc, r_o_hit, r_o_miss, r_o_fail;

    logic [AW-1:0]                 la_in;
    logic [blt_pkg::BCNT_W-1:0]    div_d, rem_s, rem_sub;
    logic [NW-1:0]                 lim;
    logic                          evict, do_ev, slot_ok, issue, pv, busy;
    logic [LW-1:0]                 slot;
    logic [blt_pkg::MAX_LINES-1:0] ev_mask;
    logic [blt_pkg::ENTRY_W-1:0]   rdata, wdata;
    logic [AW-1:0]                 rd_tag;
    logic [RW-1:0]                 rd_rank, rank_inc;
    logic                          we;

    assign la_in = i_req_address >> r_shift;

    always_comb begin
        if (r_bcnt == '0) div_d = blt_pkg::BCNT_W'(1);
        else if (r_bcnt > blt_pkg::BCNT_W'(blt_pkg::MAX_BANKS))
            div_d = blt_pkg::BCNT_W'(blt_pkg::MAX_BANKS);
        else div_d = r_bcnt;
    end

    // one quotient bit per step; remainder stays below the divisor
    assign rem_s   = {r_rem, r_dq[AW-1]};
    assign rem_sub = (rem_s >= div_d) ? (rem_s - div_d) : rem_s;

    assign lim = (r_act > blt_pkg::ACT_W'(blt_pkg::MAX_LINES))
               ? NW'(blt_pkg::MAX_LINES) : NW'(r_act);
    assign evict   = (r_rc >= lim) && (r_rc != '0);
    assign do_ev   = evict && r_vf;
    assign slot_ok = do_ev || r_hf;
    assign slot    = do_ev ? ((r_hf && (r_fs < r_vs)) ? r_fs : r_vs) : r_fs;
    assign ev_mask = do_ev ? (blt_pkg::MAX_LINES'(1) << r_vs) : '0;
    assign busy    = r_busy[r_rem] > r_now;

    assign issue    = (i_cmd.srch || i_cmd.upd) && !r_idx[NW-1] && !i_cmd.sweep_clr;
    assign rd_tag   = rdata[blt_pkg::ENTRY_W-1:RW];
    assign rd_rank  = rdata[RW-1:0];
    assign rank_inc = rd_rank + RW'(1);
    assign pv       = r_valid[r_rp];

    always_comb begin
        we    = 1'b0;
        wdata = {rd_tag, rank_inc};
        if (i_cmd.upd && r_rv) begin
            if (r_ins) begin
                if (r_rp == r_slot) begin
                    we    = 1'b1;
                    wdata = {r_la, RW'(0)};
                end else if (pv) begin
                    we = 1'b1;
                end
            end else begin
                if (r_rp == r_hs) begin
                    we    = 1'b1;
                    wdata = {rd_tag, RW'(0)};
                end else if (pv && (rd_rank < r_hr)) begin
                    we = 1'b1;
                end
            end
        end
    end

    blt_ram #(
        .WIDTH (blt_pkg::ENTRY_W),
        .DEPTH (blt_pkg::MAX_LINES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_rp),
        .i_wdata (wdata),
        .i_raddr (r_idx[LW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        o_st            = '0;
        o_st.in_fill    = (i_req_command == blt_pkg::CMD_FILL);
        o_st.enable     = r_en;
        o_st.lim_zero   = (lim == '0);
        o_st.div_done   = (r_dcnt == '0);
        o_st.bank_busy  = busy;
        o_st.sweep_done = r_idx[NW-1] && !r_rv;
        o_st.line_hit   = r_hit;
        o_st.is_fill    = r_fill;
        o_st.upd_needed = r_hit || slot_ok;
        o_st.out_free   = !r_ov || i_rsp_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_shift <= blt_pkg::SHIFT_W'(7);
            r_act   <= blt_pkg::ACT_W'(blt_pkg::MAX_LINES);
            r_bcnt  <= blt_pkg::BCNT_W'(1);
            r_pol   <= blt_pkg::POL_PLAIN;
            r_dcnt  <= '0;
            for (int b = 0; b < blt_pkg::MAX_BANKS; b++) r_busy[b] <= '0;
            r_acc   <= '0;
            r_hitc  <= '0;
            r_missc <= '0;
            r_failc <= '0;
            r_valid <= '0;
            r_rc    <= '0;
            r_idx   <= '0;
            r_rv    <= 1'b0;
            r_hit   <= 1'b0;
            r_hf    <= 1'b0;
            r_vf    <= 1'b0;
            r_ins   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    blt_pkg::CFG_ENABLE: r_en    <= i_cfg_data[0];
                    blt_pkg::CFG_SHIFT:  r_shift <= i_cfg_data[blt_pkg::SHIFT_W-1:0];
                    blt_pkg::CFG_ACTIVE: r_act   <= i_cfg_data[blt_pkg::ACT_W-1:0];
                    blt_pkg::CFG_BANKS:  r_bcnt  <= i_cfg_data[blt_pkg::BCNT_W-1:0];
                    blt_pkg::CFG_POLICY: r_pol   <= i_cfg_data[blt_pkg::POLICY_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_dcnt <= blt_pkg::DIVC_W'(AW);
                r_hit  <= 1'b0;
                r_hf   <= 1'b0;
                r_vf   <= 1'b0;
                r_ins  <= 1'b0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - blt_pkg::DIVC_W'(1);
            end

            if (i_cmd.check) begin
                r_acc <= r_acc + CW'(1);
                if (busy) r_failc <= r_failc + CW'(1);
                else r_busy[r_rem] <= r_now + blt_pkg::STAMP_W'(1);
            end

            if (i_cmd.sweep_clr) begin
                r_idx <= '0;
                r_rv  <= 1'b0;
            end else begin
                if (issue) r_idx <= r_idx + NW'(1);
                r_rv <= issue;
            end

            // first matching, first free and least recent entries
            if (i_cmd.srch && r_rv) begin
                if (pv && (rd_tag == r_la) && !r_hit) r_hit <= 1'b1;
                if (!pv && !r_hf) r_hf <= 1'b1;
                if (pv && (NW'(rd_rank) == r_rc - NW'(1)) && !r_vf) r_vf <= 1'b1;
            end

            if (i_cmd.srch_end) begin
                if (!r_fill) begin
                    if (r_hit) r_hitc <= r_hitc + CW'(1);
                    else r_missc <= r_missc + CW'(1);
                end else if (!r_hit && slot_ok) begin
                    r_ins   <= 1'b1;
                    // victim cleared, new slot set (may be the victim itself)
                    r_valid <= (r_valid & ~ev_mask) | (blt_pkg::MAX_LINES'(1) << slot);
                    if (!do_ev) r_rc <= r_rc + NW'(1);
                end
            end

            if (i_cmd.res_load) r_ov <= 1'b1;
            else if (i_rsp_ready) r_ov <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fill   <= i_req_command;
            r_la     <= la_in;
            r_now    <= i_req_now;
            r_dq     <= blt_pkg::bank_hash(la_in, r_pol);
            r_rem    <= '0;
            r_status <= blt_pkg::ST_MISS;
            r_bank   <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= r_dq << 1;
            r_rem <= rem_sub[blt_pkg::BANK_W-1:0];
        end
        if (i_cmd.check) begin
            r_bank <= r_rem;
            if (busy) r_status <= blt_pkg::ST_FAIL;
        end
        if (issue) r_rp <= r_idx[LW-1:0];
        if (i_cmd.srch && r_rv) begin
            if (pv && (rd_tag == r_la) && !r_hit) begin
                r_hs <= r_rp;
                r_hr <= rd_rank;
            end
            if (!pv && !r_hf) r_fs <= r_rp;
            if (pv && (NW'(rd_rank) == r_rc - NW'(1)) && !r_vf) r_vs <= r_rp;
        end
        if (i_cmd.srch_end) begin
            r_slot <= slot;
            if (!r_fill) r_status <= r_hit ? blt_pkg::ST_HIT : blt_pkg::ST_MISS;
        end
        if (i_cmd.res_load) begin
            r_o_status <= r_status;
            r_o_bank   <= r_bank;
            r_o_acc    <= r_acc;
            r_o_hit    <= r_hitc;
            r_o_miss   <= r_missc;
            r_o_fail   <= r_failc;
        end
    end

    assign o_rsp_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_bank         = r_o_bank;
    assign o_access_total = r_o_acc;
    assign o_hit_total    = r_o_hit;
    assign o_miss_total   = r_o_miss;
    assign o_fail_total   = r_o_fail;
endmodule

// ===== design/banked_lru_line_tracker.sv =====
// Channel  Dir  Beat contents
// i_req    in   command, address, now
// o_rsp    out  status, bank, access/hit/miss/fail totals (one per access)
// cfg      in   i_cfg_we, i_cfg_index, i_cfg_data (write only)
//
// One item at a time. Enabled access: accept, bank divide (48 steps), busy check
// (a busy bank skips to result), search sweep (+ update sweep on a hit), result.
// Fill: accept, search sweep (+ update sweep on a hit or an insert); no sweep
// with no active lines. Sweeps cover all 256 tag/rank RAM entries; the bank
// divide is bit-serial. A disabled fill is only accepted; a disabled access goes
// to result. The result step waits while the previous beat is still in the output register.
// Reset clears valid bits, counters and bank stamps at once; no clearing pass.
// A waiting result sits in the output register while the next request is taken.
// Top level of the tracker; depends on blt_pkg, blt_req_if, blt_rsp_if,
// blt_ctrl, blt_dp.
module banked_lru_line_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [blt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    blt_req_if.sink                        i_req,
    blt_rsp_if.source                      o_rsp
);
    blt_pkg::t_cmd  w_cmd;
    blt_pkg::t_stat w_st;
    logic           w_ready;

    blt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_st       (w_st),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    blt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_req_command  (i_req.command),
        .i_req_address  (i_req.address),
        .i_req_now      (i_req.now),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_bank         (o_rsp.bank),
        .o_access_total (o_rsp.access_total),
        .o_hit_total    (o_rsp.hit_total),
        .o_miss_total   (o_rsp.miss_total),
        .o_fail_total   (o_rsp.fail_total)
    );

    assign i_req.ready = w_ready;
endmodule

// ===== design/blt_checker.sv =====
// Port-level checks on the tracker's response channel, bound to the top.
// Depends on blt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [blt_pkg::STATUS_W-1:0]  i_status,
    input  logic [blt_pkg::BANK_W-1:0]    i_bank,
    input  logic [blt_pkg::CTR_W-1:0]     i_acc,
    input  logic [blt_pkg::CTR_W-1:0]     i_hit,
    input  logic [blt_pkg::CTR_W-1:0]     i_miss,
    input  logic [blt_pkg::CTR_W-1:0]     i_fail
);
    // every counted access lands in exactly one of hit, miss, fail
    `BLT_ASSERT(a_totals_sum, i_clk, i_rst_n, i_rsp_valid |-> (blt_pkg::CTR_W'(i_hit + i_miss + i_fail) == i_acc), "totals do not add up")
    `BLT_ASSERT(a_status_code, i_clk, i_rst_n, i_rsp_valid |-> (i_status == blt_pkg::ST_HIT || i_status == blt_pkg::ST_MISS || i_status == blt_pkg::ST_FAIL), "bad status code")
    `BLT_ASSERT(a_beat_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status) && $stable(i_bank) && $stable(i_acc)), "stalled beat changed")
    `BLT_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_rsp_valid, "response valid after reset")
endmodule

bind banked_lru_line_tracker blt_checker u_blt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_bank      (o_rsp.bank),
    .i_acc       (o_rsp.access_total),
    .i_hit       (o_rsp.hit_total),
    .i_miss      (o_rsp.miss_total),
    .i_fail      (o_rsp.fail_total)
);
